// ----- rtl/core/lidar_frame_parser_core_assert.svh -----
// Assertion macros shared by the frame parser RTL.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef LIDAR_FRAME_PARSER_CORE_ASSERT_SVH
`define LIDAR_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfp assertion failed");

// Next-cycle implication.
`define LFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfp assertion failed");

`endif

// ----- rtl/core/lfp_pkg.sv -----
package lfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MEAS_W      = 17;
    localparam int unsigned IDX_W       = 3;

    localparam logic [BYTE_W-1:0] SYNC_BYTE         = 8'h59;
    localparam logic [BYTE_W-1:0] SUM_START         = 8'hB2;
    localparam logic [BYTE_W-1:0] QUALITY_MIN_RESET = 8'd7;

    // Payload byte positions.
    localparam logic [IDX_W-1:0] IDX_DIST_LO = 3'd0;
    localparam logic [IDX_W-1:0] IDX_DIST_HI = 3'd1;
    localparam logic [IDX_W-1:0] IDX_QUALITY = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LAST    = 3'd5;

    typedef logic [BYTE_W-1:0]        t_byte;
    typedef logic signed [MEAS_W-1:0] t_meas;

    // One result handed from the parser to the output stage.
    typedef struct packed {
        logic  vld;
        t_meas meas;
    } t_res;

endpackage

// ----- rtl/core/lfp_rx_if.sv -----
interface lfp_rx_if;
    import lfp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/lfp_meas_if.sv -----
interface lfp_meas_if;
    import lfp_pkg::*;

    logic  valid;
    logic  ready;
    t_meas measured_distance;

    modport source (output valid, output measured_distance, input ready);
    modport sink   (input valid, input measured_distance, output ready);
endinterface

// ----- rtl/core/lidar_frame_parser_core.sv -----
// Channel   Direction  Payload                        Meaning
// i_rx      in         rx_byte [7:0]                  one received serial byte
// o_meas    out        measured_distance [16:0] s     distance, or -1 on low quality
// i_cfg_*   in         i_cfg_wdata [7:0]              quality_min, written when i_cfg_we
//
// One byte is taken every cycle while i_rx.ready is high. A byte is held in the input
// register and parsed there; a result reaches o_meas from the output register.
// Reset is synchronous and active low; quality_min returns to 7 and the hunt restarts.
// Stalls on o_meas fill a one-entry skid buffer first, then hold i_rx.ready low.
module lidar_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfp_rx_if.sink      i_rx,
    lfp_meas_if.source  o_meas,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import lfp_pkg::*;

    `include "lidar_frame_parser_core_assert.svh"

    // Result from the parser and room in the output stage.
    t_res w_res;
    logic w_out_rdy;

    // The parser holds the phase state machine, the running checksum and the
    // payload bytes that form the result (distance low, distance high, quality).
    lfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_out_rdy   (w_out_rdy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (w_res)
    );

    // The output stage is a result register plus a skid entry, so a stalled
    // consumer never stalls the parser for the cycle in which it stalls.
    lfp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_rdy   (w_out_rdy),
        .o_meas  (o_meas)
    );

    // A result is only produced when the output stage can take it.
    `LFP_ASSERT_NOW(a_res_has_room, w_res.vld, w_out_rdy)

    // While the output stage has room, the input side never stalls.
    `LFP_ASSERT_NOW(a_rx_ready_when_room, w_out_rdy, i_rx.ready)

    // A result is either a 16-bit distance or all ones.
    `LFP_ASSERT_NOW(a_res_range, w_res.vld,
                    (w_res.meas[MEAS_W-1] == 1'b0) || (w_res.meas == '1))

endmodule

// ----- rtl/core/lfp_parser.sv -----
module lfp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lfp_rx_if.sink                i_rx,
    input  logic                  i_out_rdy,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    output lfp_pkg::t_res         o_res
);
    import lfp_pkg::*;

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_PAYLOAD,
        PH_CKSUM
    } t_phase;

    t_phase           r_phase;
    logic [IDX_W-1:0] r_idx;
    t_byte            r_sum;
    t_byte            r_qmin;
    logic             r_in_vld;
    t_byte            r_in_byte;
    t_byte            r_dist_lo;
    t_byte            r_dist_hi;
    t_byte            r_quality;

    logic  w_proc;
    logic  w_accept;
    t_byte w_sum_add;

    // The held byte is consumed whenever the output stage has room.
    assign w_proc     = r_in_vld && i_out_rdy;
    assign i_rx.ready = !r_in_vld || i_out_rdy;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_sum_add  = r_sum + r_in_byte;

    always_comb begin
        o_res.vld  = w_proc && (r_phase == PH_CKSUM) && (r_in_byte == r_sum);
        o_res.meas = (r_quality >= r_qmin) ? t_meas'({1'b0, r_dist_hi, r_dist_lo})
                                           : '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_idx    <= '0;
            r_sum    <= SUM_START;
            r_qmin   <= QUALITY_MIN_RESET;
            r_in_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_qmin <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_proc) begin
                r_in_vld <= 1'b0;
            end
            if (w_proc) begin
                case (r_phase)
                    PH_SYNC1: begin
                        if (r_in_byte == SYNC_BYTE) begin
                            r_phase <= PH_SYNC2;
                        end
                    end
                    PH_SYNC2: begin
                        r_phase <= (r_in_byte == SYNC_BYTE) ? PH_PAYLOAD : PH_SYNC1;
                    end
                    PH_PAYLOAD: begin
                        r_sum <= w_sum_add;
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == IDX_LAST) begin
                            r_phase <= PH_CKSUM;
                        end
                    end
                    default: begin
                        r_phase <= PH_SYNC1;
                        r_idx   <= '0;
                        r_sum   <= SUM_START;
                    end
                endcase
            end
        end
    end

    // Only the payload bytes that feed the result are kept.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_proc && (r_phase == PH_PAYLOAD)) begin
            if (r_idx == IDX_DIST_LO) begin
                r_dist_lo <= r_in_byte;
            end
            if (r_idx == IDX_DIST_HI) begin
                r_dist_hi <= r_in_byte;
            end
            if (r_idx == IDX_QUALITY) begin
                r_quality <= r_in_byte;
            end
        end
    end

endmodule

// ----- rtl/core/lfp_out_stage.sv -----
module lfp_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lfp_pkg::t_res         i_res,
    output logic                  o_rdy,
    lfp_meas_if.source            o_meas
);
    import lfp_pkg::*;

    logic  r_main_vld;
    t_meas r_main;
    logic  r_skid_vld;
    t_meas r_skid;

    logic w_pop;
    logic w_push;

    // Ready to the parser depends on registered state only.
    assign o_rdy  = !r_skid_vld;
    assign w_push = i_res.vld && o_rdy;
    assign w_pop  = r_main_vld && o_meas.ready;

    assign o_meas.valid             = r_main_vld;
    assign o_meas.measured_distance = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_main_vld || w_pop) begin
                if (r_skid_vld) begin
                    r_main_vld <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_main_vld <= w_push;
                end
            end else if (w_push) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_vld || w_pop) begin
            r_main <= r_skid_vld ? r_skid : i_res.meas;
        end else if (w_push) begin
            r_skid <= i_res.meas;
        end
    end

endmodule
